### rtl/core/bsfd_pkg.sv
// Shared types and constants for the byte-stuffed frame decoder.
package bsfd_pkg;

  localparam int unsigned CntW = 13;
  localparam int unsigned ByteW = 8;

  // Hard ceiling on the frame length limit.
  localparam logic [CntW-1:0] MaxFrameBytes = 13'd4096;

  localparam logic [ByteW-1:0] FlagByte = 8'h7E;
  localparam logic [ByteW-1:0] EscByte  = 8'h7D;
  localparam logic [ByteW-1:0] EscXor   = 8'h20;

  localparam logic [CntW-1:0] CfgResetLimit = 13'd512;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_DROP = 2'd2
  } kind_e;

  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic [CntW-1:0]  position;
    logic             last;
  } result_t;

endpackage

### rtl/core/bsfd_parser.sv
// Deframing state machine: mode, byte counter and per-word result.
module bsfd_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [bsfd_pkg::ByteW-1:0] byte_i,
  input  logic [bsfd_pkg::CntW-1:0]  limit_i,
  output bsfd_pkg::result_t          result_o
);
  import bsfd_pkg::*;

  typedef enum logic [1:0] {
    MODE_WAIT = 2'd0,
    MODE_READ = 2'd1,
    MODE_ESC  = 2'd2
  } mode_e;

  mode_e           mode_q, mode_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    logic             pay_en;
    logic [ByteW-1:0] pay_byte;
    pay_en   = 1'b0;
    pay_byte = byte_i;
    result_o = '0;
    mode_d   = mode_q;
    cnt_d    = cnt_q;

    if (byte_i == FlagByte) begin
      // flag closes a non-empty frame; a pending escape is dropped
      if ((mode_q == MODE_READ || mode_q == MODE_ESC) && cnt_q != '0) begin
        result_o.valid    = 1'b1;
        result_o.kind     = KIND_END;
        result_o.position = cnt_q;
        result_o.last     = 1'b1;
      end
      mode_d = MODE_READ;
      cnt_d  = '0;
    end else begin
      case (mode_q)
        MODE_READ: begin
          if (byte_i == EscByte) begin
            mode_d = MODE_ESC;
          end else begin
            pay_en = 1'b1;
          end
        end
        MODE_ESC: begin
          pay_byte = byte_i ^ EscXor;
          pay_en   = 1'b1;
          mode_d   = MODE_READ;
        end
        default: begin
          mode_d = MODE_WAIT;
        end
      endcase
    end

    if (pay_en) begin
      if (cnt_q >= limit_i) begin
        result_o.valid    = 1'b1;
        result_o.kind     = KIND_DROP;
        result_o.position = cnt_q;
        result_o.last     = 1'b1;
        mode_d            = MODE_WAIT;
        cnt_d             = '0;
      end else begin
        result_o.valid    = 1'b1;
        result_o.kind     = KIND_DATA;
        result_o.data     = pay_byte;
        result_o.position = cnt_q;
        cnt_d             = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_WAIT;
      cnt_q  <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

### rtl/core/byte_stuffed_frame_decoder.sv
// Top level of the byte-stuffed (HDLC-style) frame decoder.
//
// Input stream: one raw line byte per word on s_axis. 0x7E is the frame
// flag, 0x7D escapes the following byte (XOR 0x20). Bytes before the first
// flag after reset are discarded.
// Output stream: at most one word per input byte. tuser carries the kind
// (payload, frame end, dropped); tdata carries the unescaped byte and the
// position (byte index, or frame length on a frame end); tlast marks the
// frame end or drop word.
// Config: cfg_we_i writes max_frame_len; zero reads as 1, values above
// 4096 saturate. Write only while the stream is idle.
// Output timing: a result is registered and appears on m_axis in the cycle after its byte is taken.
// Throughput: one byte per cycle; the only limit is the single output
// register, which refills in the same cycle it is drained.
// Stall: while the output word waits and m_axis_tready is low, s_axis_tready
// drops; nothing is lost. Bytes that produce no result pass straight through
// the state logic whenever the output register has room.
// Reset: asynchronous, active low; decoder waits for a flag, count is
// cleared, limit returns to 512, output register empties.
module byte_stuffed_frame_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // config
  input  logic                      cfg_we_i,
  input  logic [bsfd_pkg::CntW-1:0] cfg_wdata_i,   // max_frame_len
  // input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // [7:0] in_byte
  // output stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [23:0]               m_axis_tdata,  // [7:0] out_byte, [20:8] out_position
  output logic [1:0]                m_axis_tuser,  // [1:0] out_kind
  output logic                      m_axis_tlast   // out_last
);
  import bsfd_pkg::*;

  logic [CntW-1:0] limit_cfg_q;
  logic [CntW-1:0] limit_eff;
  logic            in_accept;
  result_t         res;
  result_t         out_q;
  logic            out_valid_q;

  // clamp limit into [1, MaxFrameBytes]
  always_comb begin
    if (limit_cfg_q == '0) begin
      limit_eff = CntW'(1);
    end else if (limit_cfg_q > MaxFrameBytes) begin
      limit_eff = MaxFrameBytes;
    end else begin
      limit_eff = limit_cfg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_cfg_q <= CfgResetLimit;
    end else if (cfg_we_i) begin
      limit_cfg_q <= cfg_wdata_i;
    end
  end

  // output register frees up in the cycle it is drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  bsfd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (s_axis_tdata),
    .limit_i  (limit_eff),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= in_accept && res.valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.position, out_q.data};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

endmodule
